// ----- rtl/core/dpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the disk pack controller register block.
// ----------------------------------------------------------------------------
package dpc_pkg;

	// Item opcodes (bus accesses and timer events)
	typedef enum logic [3:0] {
		OP_DOA       = 4'd0,
		OP_DIA       = 4'd1,
		OP_DOB       = 4'd2,
		OP_DIB       = 4'd3,
		OP_DOC       = 4'd4,
		OP_DIC       = 4'd5,
		OP_NIO       = 4'd6,
		OP_STEP_TMR  = 4'd7,
		OP_IRQ_TMR   = 4'd8
	} opcode_t;

	// Bus control pulses
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_START = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_PULSE = 2'd3
	} action_t;

	// Command field of register A, bits 9:8
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_SEEK  = 2'd2,
		CMD_RECAL = 2'd3
	} cmd_t;

	// Timer request codes
	typedef enum logic [2:0] {
		TMR_NONE       = 3'd0,
		TMR_SHORT_STEP = 3'd1,
		TMR_LONG_STEP  = 3'd2,
		TMR_SHORT_IRQ  = 3'd3,
		TMR_LONG_IRQ   = 3'd4
	} tmr_req_t;

	localparam int          NUM_DRIVES_DEF        = 4;
	localparam int          SECTORS_PER_TRACK_DEF = 12;

	localparam logic [15:0] STATUS_RESET     = 16'h0040;
	localparam logic [15:0] STATUS_DOA_MASK  = 16'hf800;
	localparam logic [15:0] STATUS_LOW_MASK  = 16'h003f;
	localparam logic [15:0] STATUS_DONE      = 16'h8000;
	localparam logic [15:0] STATUS_DRV0      = 16'h4000;
	localparam logic [15:0] C_STEP_INC       = 16'h0011;
	localparam logic [15:0] C_SECTOR_DEC     = 16'h0010;
	localparam logic [15:0] SECTOR_WORDS     = 16'h0100;
	localparam logic [15:0] WRITE_ADDR_EXTRA = 16'h0002;

	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 6;
	localparam int RES_W       = 65;
	localparam int OUT_TDATA_W = 72;

	// Result item, first field in the highest bits
	typedef struct packed {
		tmr_req_t    timer_request;
		logic [12:0] xfer_words;
		logic [15:0] xfer_mem_addr;
		logic [12:0] xfer_sector;
		logic        xfer_to_disk;
		logic        xfer_valid;
		logic        busy_res;
		logic        irq;
		logic [15:0] read_data;
	} result_t;

endpackage

// ----- rtl/core/disk_pack_controller_registers.sv -----
// ----------------------------------------------------------------------------
// disk_pack_controller_registers
// Register model of a four-drive disk pack controller: bus accesses, command
// start, sector steps, transfer descriptors and timer requests.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data; tuser: opcode, action
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: one result per item
//
//  An item is registered in the input stage, then updates the controller
//  state and loads the result register in one pass; one item per cycle
//  is sustained while the output does not stall. The result register
//  stalls the input stage only while a result waits and m_axis_tready is low.
//  Reset (arst_n low) clears the valid flags and the controller state; status reads 0x0040.
// ----------------------------------------------------------------------------
module disk_pack_controller_registers
	import dpc_pkg::*;
#(
	parameter int NUM_DRIVES        = NUM_DRIVES_DEF,
	parameter int SECTORS_PER_TRACK = SECTORS_PER_TRACK_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] data
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [3:0] opcode, [5:4] action
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [15:0] read_data, [16] irq, [17] busy_res, [18] xfer_valid,
	// [19] xfer_to_disk, [32:20] xfer_sector, [48:33] xfer_mem_addr,
	// [61:49] xfer_words, [64:62] timer_request, [71:65] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam logic [4:0]  SptW        = 5'(SECTORS_PER_TRACK);
	localparam logic [15:0] SecWrapAdd  = 16'((16 - SECTORS_PER_TRACK) * 16);
	localparam logic [12:0] TrackSpt    = 13'(SECTORS_PER_TRACK);
	localparam logic [12:0] CylSpt      = 13'(2 * SECTORS_PER_TRACK);

	// Input stage
	logic        valid_s1;
	logic [3:0]  opcode_s1;
	logic [1:0]  action_s1;
	logic [15:0] data_s1;

	// Controller state
	logic [15:0] reg_a_q, reg_b_q, reg_c_q, status_q;
	logic [1:0]  drv_sel_q;
	logic [7:0]  cyl_q [NUM_DRIVES];
	logic        busy_q, irq_q;

	// Result register
	logic        out_valid_q;
	result_t     res_q;

	// Next state
	logic [15:0] reg_a_d, reg_b_d, reg_c_d, status_d;
	logic [1:0]  drv_sel_d;
	logic [7:0]  cyl_d [NUM_DRIVES];
	logic        busy_d, irq_d;
	result_t     res_d;

	logic        advance, fire, bus_op;
	logic [7:0]  cur_cyl;
	logic [15:0] c_adj, c_step, drv_bit;
	logic [4:0]  n_sec;

	// Linear sector: sector + head*SPT + cylinder*2*SPT, 13 bits
	function automatic logic [12:0] lin_sector(input logic [15:0] c, input logic [7:0] cyl);
		logic [12:0] s, h, y;
		s = {9'd0, c[7:4]};
		h = 13'({8'd0, c[12:8]} * TrackSpt);
		y = 13'({5'd0, cyl} * CylSpt);
		return 13'(s + h + y);
	endfunction

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= s_axis_tuser[3:0];
			action_s1 <= s_axis_tuser[5:4];
			data_s1   <= s_axis_tdata;
		end
	end

	// Item execution
	always_comb begin
		reg_a_d   = reg_a_q;
		reg_b_d   = reg_b_q;
		reg_c_d   = reg_c_q;
		status_d  = status_q;
		drv_sel_d = drv_sel_q;
		cyl_d     = cyl_q;
		busy_d    = busy_q;
		irq_d     = irq_q;
		res_d     = '0;
		bus_op    = 1'b0;
		c_adj     = reg_c_q;
		c_step    = reg_c_q;
		cur_cyl   = '0;
		drv_bit   = '0;
		n_sec     = '0;

		// Bus access or timer event
		case (opcode_s1)
			OP_DOA: begin
				reg_a_d  = data_s1;
				status_d = status_q & ~(data_s1 & STATUS_DOA_MASK);
				irq_d    = 1'b0;
				bus_op   = 1'b1;
			end
			OP_DIA: begin
				res_d.read_data = status_q;
				bus_op          = 1'b1;
			end
			OP_DOB: begin
				reg_b_d = data_s1;
				bus_op  = 1'b1;
			end
			OP_DIB: begin
				res_d.read_data = reg_b_q;
				bus_op          = 1'b1;
			end
			OP_DOC: begin
				reg_c_d   = data_s1;
				drv_sel_d = data_s1[15:14];
				bus_op    = 1'b1;
			end
			OP_DIC: begin
				res_d.read_data = reg_c_q;
				bus_op          = 1'b1;
			end
			OP_NIO: begin
				reg_a_d = '0;
				reg_b_d = '0;
				reg_c_d = '0;
				bus_op  = 1'b1;
			end
			default: ;
		endcase

		// Drive-dependent terms, after any DOC
		for (int i = 0; i < NUM_DRIVES; i++) begin
			if (drv_sel_d == 2'(i)) begin
				cur_cyl = cyl_q[i];
			end
		end
		drv_bit = STATUS_DRV0 >> drv_sel_d;

		// Timer events
		if (opcode_s1 == OP_STEP_TMR) begin
			// sector past track end wraps into the next head
			c_adj = ({1'b0, reg_c_q[7:4]} >= SptW) ? 16'(reg_c_q + SecWrapAdd) : reg_c_q;
			res_d.xfer_valid    = 1'b1;
			res_d.xfer_sector   = lin_sector(c_adj, cur_cyl);
			res_d.xfer_mem_addr = reg_b_q;
			res_d.xfer_words    = 13'(SECTOR_WORDS);
			reg_b_d = 16'(reg_b_q + SECTOR_WORDS);
			c_step  = 16'(c_adj + C_STEP_INC);
			if (c_step[3:0] != 4'd0) begin
				reg_c_d             = c_step;
				res_d.timer_request = TMR_SHORT_STEP;
			end else begin
				reg_c_d  = 16'(c_step - C_SECTOR_DEC);
				status_d = status_q | STATUS_DONE | drv_bit;
				irq_d    = 1'b1;
				busy_d   = 1'b0;
			end
		end else if (opcode_s1 == OP_IRQ_TMR) begin
			irq_d  = 1'b1;
			busy_d = 1'b0;
		end

		// Control pulse on bus accesses
		if (bus_op) begin
			case (action_s1) inside
				ACT_CLEAR: irq_d = 1'b0;
				ACT_START, ACT_PULSE: begin
					status_d = status_d & ~STATUS_LOW_MASK;
					busy_d   = 1'b1;
					n_sec    = 5'(5'd16 - {1'b0, reg_c_d[3:0]});
					unique case (cmd_t'(reg_a_d[9:8]))
						CMD_READ: res_d.timer_request = TMR_LONG_STEP;
						CMD_WRITE: begin
							res_d.xfer_valid    = 1'b1;
							res_d.xfer_to_disk  = 1'b1;
							res_d.xfer_sector   = lin_sector(reg_c_d, cur_cyl);
							res_d.xfer_mem_addr = reg_b_d;
							res_d.xfer_words    = {n_sec, 8'd0};
							reg_b_d  = 16'(reg_b_d + {3'd0, n_sec, 8'd0} + WRITE_ADDR_EXTRA);
							status_d = status_d | STATUS_DONE | drv_bit;
							res_d.timer_request = TMR_LONG_IRQ;
						end
						CMD_SEEK: begin
							for (int i = 0; i < NUM_DRIVES; i++) begin
								if (drv_sel_d == 2'(i)) begin
									cyl_d[i] = reg_a_d[7:0];
								end
							end
							status_d = status_d | drv_bit;
							res_d.timer_request = TMR_SHORT_IRQ;
						end
						CMD_RECAL: begin
							for (int i = 0; i < NUM_DRIVES; i++) begin
								if (drv_sel_d == 2'(i)) begin
									cyl_d[i] = '0;
								end
							end
							reg_c_d  = '0;
							status_d = status_d | drv_bit;
							res_d.timer_request = TMR_LONG_IRQ;
						end
					endcase
				end
				default: ;
			endcase
		end

		res_d.irq      = irq_d;
		res_d.busy_res = busy_d;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_a_q   <= '0;
			reg_b_q   <= '0;
			reg_c_q   <= '0;
			status_q  <= STATUS_RESET;
			drv_sel_q <= '0;
			busy_q    <= 1'b0;
			irq_q     <= 1'b0;
			for (int i = 0; i < NUM_DRIVES; i++) begin
				cyl_q[i] <= '0;
			end
		end else if (fire) begin
			reg_a_q   <= reg_a_d;
			reg_b_q   <= reg_b_d;
			reg_c_q   <= reg_c_d;
			status_q  <= status_d;
			drv_sel_q <= drv_sel_d;
			busy_q    <= busy_d;
			irq_q     <= irq_d;
			cyl_q     <= cyl_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_q};

	// Checks
	a_tmr_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.timer_request == TMR_NONE ||
			res_q.timer_request == TMR_SHORT_STEP || res_q.timer_request == TMR_LONG_STEP ||
			res_q.timer_request == TMR_SHORT_IRQ || res_q.timer_request == TMR_LONG_IRQ))
		else $error("timer request code out of range");

	a_no_xfer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.xfer_valid) |-> (!res_q.xfer_to_disk &&
			res_q.xfer_sector == '0 && res_q.xfer_mem_addr == '0 && res_q.xfer_words == '0))
		else $error("descriptor fields set without a transfer");

	a_read_words: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.xfer_valid && !res_q.xfer_to_disk) |->
			res_q.xfer_words == 13'(SECTOR_WORDS))
		else $error("read step must move one sector");

	a_busy_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && busy_d) |=> busy_q)
		else $error("busy flag lost after item");

endmodule
